// ===== rtl/spfa_pkg.sv =====
// Shared types and constants for the single-precision float adder.
`default_nettype none
package spfa_pkg;

    localparam int unsigned GuardBits = 30;
    localparam int unsigned TopBit    = 23 + GuardBits;
    localparam logic [22:0] FracMask  = 23'h7FFFFF;
    localparam logic [7:0]  ExpMax    = 8'hFF;

    typedef struct packed {
        logic [31:0] a_bits;
        logic [31:0] b_bits;
    } spfa_in_t;

    typedef struct packed {
        logic [31:0] sum_bits;
        logic        overflow;
        logic        underflow;
    } spfa_out_t;

    // Classified operand pair handed from the front part to the back part.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic        sub;
        logic [7:0]  exp_big;
        logic [23:0] man_big;
        logic [23:0] man_small;
        logic        small_zero;
        logic [7:0]  exp_diff;
    } spfa_cls_t;

endpackage
`default_nettype wire

// ===== rtl/single_precision_float_adder.sv =====
// Single-precision float adder, truncating toward zero.
// Use: present an operand pair on in_data with in_valid; a transfer happens
// when in_valid and in_ready are both high at a rising edge of clk. Each
// operand pair gives exactly one result on out_data (sum_bits, overflow,
// underflow), transferred when out_valid and out_ready are both high.
// Throughput is one operand pair per cycle while out_ready is high. The path
// has four register stages: the front register, the two-entry queue, the
// aligned-sum stage and the result register. The front register loads at the
// input transfer edge; the pair then passes through the queue, the aligned-sum
// stage and the result register, which drives out_valid. The aligned add and
// the leading-one search each take one stage of the back part.
// Zero-exponent operands count as zero; exponent overflow gives infinity with
// the overflow flag, underflow gives signed zero with the underflow flag.
// rst_n is asynchronous and active low and empties every stage and the queue.
// When the receiver holds out_ready low, results stay in the back part and
// queue; the front accepts until the queue and its register are full, then
// in_ready falls. No result is lost or repeated under any stall pattern.
`default_nettype none
module single_precision_float_adder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire spfa_pkg::spfa_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spfa_pkg::spfa_out_t      out_data
);
    import spfa_pkg::*;

    logic      f_valid;
    logic      f_ready;
    spfa_cls_t f_data;
    logic      q_valid;
    logic      q_ready;
    spfa_cls_t q_data;

    spfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_data  (f_data)
    );

    spfa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    spfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_data  (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/spfa_front.sv =====
// Front part: unpacks, orders by magnitude and detects zero cases.
`default_nettype none
module spfa_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spfa_pkg::spfa_in_t in_data,
    output logic                    cls_valid,
    input  wire logic               cls_ready,
    output spfa_pkg::spfa_cls_t     cls_data
);
    import spfa_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    spfa_cls_t   data_reg;
    spfa_cls_t   data_next;
    logic [30:0] ka;
    logic [30:0] kb;
    logic [30:0] big;
    logic [30:0] small_key;
    logic        sa;
    logic        sb;
    logic        sbig;
    logic        ssmall;

    // Magnitude keys: zero exponent counts as zero.
    always_comb
    begin
        ka = (in_data.a_bits[30:23] == 8'd0) ? 31'd0 : in_data.a_bits[30:0];
        kb = (in_data.b_bits[30:23] == 8'd0) ? 31'd0 : in_data.b_bits[30:0];
        sa = in_data.a_bits[31];
        sb = in_data.b_bits[31];
        if (ka >= kb)
        begin
            big = ka; small_key = kb; sbig = sa; ssmall = sb;
        end
        else
        begin
            big = kb; small_key = ka; sbig = sb; ssmall = sa;
        end
    end

    // Classification of the operand pair.
    always_comb
    begin
        data_next.special      = 1'b0;
        data_next.special_bits = 32'd0;
        if (big == 31'd0)
        begin
            data_next.special      = 1'b1;
            data_next.special_bits = {sa & sb, 31'd0};
        end
        else if (big == small_key && sbig != ssmall)
        begin
            data_next.special = 1'b1;
        end
        data_next.sign       = sbig;
        data_next.sub        = sbig ^ ssmall;
        data_next.exp_big    = big[30:23];
        data_next.man_big    = {1'b1, big[22:0]};
        data_next.man_small  = {1'b1, small_key[22:0]};
        data_next.small_zero = (small_key == 31'd0);
        data_next.exp_diff   = big[30:23] - small_key[30:23];
    end

    assign in_ready  = !valid_reg || cls_ready;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !cls_ready);

    // Output register of the front part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_data  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/spfa_queue.sv =====
// Two-entry queue between the front and back parts.
`default_nettype none
module spfa_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire spfa_pkg::spfa_cls_t wr_data,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output spfa_pkg::spfa_cls_t      rd_data
);
    import spfa_pkg::*;

    spfa_cls_t   mem_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_fire;
    logic        rd_fire;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];
    assign count_next = count_reg + {1'b0, wr_fire} - {1'b0, rd_fire};

    // Storage is written at the write pointer.
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_fire)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_fire)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    property p_no_over;
        @(posedge clk) disable iff (!rst_n) count_reg == 2'd2 |-> !wr_ready;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue over-filled");

    property p_count_max;
        @(posedge clk) disable iff (!rst_n) count_reg != 2'd3;
    endproperty
    a_count_max: assert property (p_count_max) else $error("queue count invalid");

    property p_ptr_gap;
        @(posedge clk) disable iff (!rst_n)
            (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers inconsistent");

endmodule
`default_nettype wire

// ===== rtl/spfa_back.sv =====
// Back part: align, add or subtract, normalise and pack, in two stages.
`default_nettype none
module spfa_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cls_valid,
    output logic                     cls_ready,
    input  wire spfa_pkg::spfa_cls_t cls_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spfa_pkg::spfa_out_t      out_data
);
    import spfa_pkg::*;

    // Stage one: aligned sum.
    logic        s1_valid_reg;
    logic        s1_ready;
    logic        s1_special_reg;
    logic [31:0] s1_special_bits_reg;
    logic        s1_sign_reg;
    logic [7:0]  s1_exp_reg;
    logic [54:0] s1_sum_reg;
    logic [54:0] sum_next;
    logic [53:0] vbig;
    logic [53:0] vsmall;
    logic [53:0] vfull;
    logic [53:0] shifted;
    logic [53:0] lost_mask;
    logic        sticky;

    // Stage two: result register.
    logic        s2_valid_reg;
    spfa_out_t   s2_data_reg;
    spfa_out_t   s2_data_next;
    logic        s2_ready;

    logic [5:0]  lz;
    logic        found;
    logic [54:0] norm;
    logic signed [9:0] e_res;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cls_ready = s1_ready;

    // Alignment with sticky bit, then the magnitude add or subtract.
    always_comb
    begin
        vbig  = {cls_data.man_big, 30'd0};
        vfull = {cls_data.man_small, 30'd0};
        if (cls_data.exp_diff >= 8'd54)
        begin
            shifted   = 54'd0;
            lost_mask = {54{1'b1}};
        end
        else
        begin
            shifted   = vfull >> cls_data.exp_diff[5:0];
            lost_mask = ~({54{1'b1}} << cls_data.exp_diff[5:0]);
        end
        sticky = |(vfull & lost_mask);
        vsmall = cls_data.small_zero ? 54'd0 : (shifted | {53'd0, sticky});
        if (cls_data.sub)
        begin
            sum_next = {1'b0, vbig} - {1'b0, vsmall};
        end
        else
        begin
            sum_next = {1'b0, vbig} + {1'b0, vsmall};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && cls_valid)
        begin
            s1_special_reg      <= cls_data.special;
            s1_special_bits_reg <= cls_data.special_bits;
            s1_sign_reg         <= cls_data.sign;
            s1_exp_reg          <= cls_data.exp_big;
            s1_sum_reg          <= sum_next;
        end
    end

    // Leading-one position, counted from bit 54 downwards.
    always_comb
    begin
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 54; i >= 0; i--)
        begin
            if (!found && s1_sum_reg[i])
            begin
                found = 1'b1;
                lz    = 6'(54 - i);
            end
        end
    end

    // Normalisation and packing.
    always_comb
    begin
        if (lz == 6'd0)
        begin
            norm = s1_sum_reg >> 1;
        end
        else
        begin
            norm = s1_sum_reg << (lz - 6'd1);
        end
        e_res = $signed({2'b00, s1_exp_reg}) + 10'sd1 - $signed({4'd0, lz});
        s2_data_next.overflow  = 1'b0;
        s2_data_next.underflow = 1'b0;
        if (s1_special_reg)
        begin
            s2_data_next.sum_bits = s1_special_bits_reg;
        end
        else if (e_res >= 10'sd255)
        begin
            s2_data_next.sum_bits = {s1_sign_reg, ExpMax, 23'd0};
            s2_data_next.overflow = 1'b1;
        end
        else if (e_res <= 10'sd0)
        begin
            s2_data_next.sum_bits  = {s1_sign_reg, 31'd0};
            s2_data_next.underflow = 1'b1;
        end
        else
        begin
            s2_data_next.sum_bits = {s1_sign_reg, e_res[7:0],
                                     norm[52:30] & FracMask};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    property p_flags_excl;
        @(posedge clk) disable iff (!rst_n)
            out_valid |-> !(out_data.overflow && out_data.underflow);
    endproperty
    a_flags_excl: assert property (p_flags_excl) else $error("both flags set");

    property p_ovf_pattern;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && out_data.overflow) |-> (out_data.sum_bits[30:0] == {ExpMax, 23'd0});
    endproperty
    a_ovf_pattern: assert property (p_ovf_pattern) else $error("bad overflow pattern");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !out_ready) |=> out_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped while stalled");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the single-precision float adder.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import spfa_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    spfa_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    spfa_out_t out_data;

    single_precision_float_adder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    spfa_out_t expected_sums[$];
    int        error_count;
    int        sums_checked;
    int        items_sent;
    int        overflow_seen;
    int        underflow_seen;
    int        hold_cycles;
    bit        stall_random;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predicts the truncated sum of two operand bit patterns.
    function automatic spfa_out_t predict_sum(input logic [31:0] a, input logic [31:0] b);
        logic [30:0] mag_a;
        logic [30:0] mag_b;
        logic [30:0] mag_big;
        logic [30:0] mag_small;
        logic        sign_big;
        logic        sign_small;
        logic [7:0]  exp_big;
        logic [7:0]  shift;
        logic [63:0] val_big;
        logic [63:0] val_small;
        logic [63:0] val_raw;
        logic [63:0] total;
        int          lead;
        int          exp_res;
        spfa_out_t   res;
        mag_a = (a[30:23] == 8'd0) ? 31'd0 : a[30:0];
        mag_b = (b[30:23] == 8'd0) ? 31'd0 : b[30:0];
        res = '0;
        if (mag_a >= mag_b)
        begin
            mag_big = mag_a; sign_big = a[31]; mag_small = mag_b; sign_small = b[31];
        end
        else
        begin
            mag_big = mag_b; sign_big = b[31]; mag_small = mag_a; sign_small = a[31];
        end
        if (mag_big == 31'd0)
            res.sum_bits = {a[31] & b[31], 31'd0};
        else if (mag_big == mag_small && sign_big != sign_small)
            res.sum_bits = 32'd0;
        else
        begin
            exp_big = mag_big[30:23];
            val_big = {40'd0, 1'b1, mag_big[22:0]} << GuardBits;
            val_small = 64'd0;
            if (mag_small != 31'd0)
            begin
                // Alignment keeps a sticky bit for anything shifted out.
                shift = exp_big - mag_small[30:23];
                val_raw = {40'd0, 1'b1, mag_small[22:0]} << GuardBits;
                if (shift >= 8'd63)
                    val_small = 64'd1;
                else
                begin
                    val_small = val_raw >> shift;
                    if ((val_small << shift) != val_raw)
                        val_small[0] = 1'b1;
                end
            end
            total = (sign_big == sign_small) ? val_big + val_small : val_big - val_small;
            lead = TopBit + 1;
            while (lead > 0 && total[lead] == 1'b0)
                lead--;
            if (lead > TopBit)
                total = total >> (lead - TopBit);
            else
                total = total << (TopBit - lead);
            exp_res = int'(exp_big) + lead - TopBit;
            if (exp_res >= 255)
            begin
                res.sum_bits = {sign_big, ExpMax, 23'd0};
                res.overflow = 1'b1;
            end
            else if (exp_res <= 0)
            begin
                res.sum_bits = {sign_big, 31'd0};
                res.underflow = 1'b1;
            end
            else
                res.sum_bits = {sign_big, exp_res[7:0], total[GuardBits +: 23] & FracMask};
        end
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one operand pair, with a random gap first when out of a burst.
    int burst_left;
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{a_bits: a, b_bits: b};
        expected_sums.push_back(predict_sum(a, b));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Receiver stall pattern, with a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (stall_random)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    // Checks each transferred result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                report_mismatch("unexpected result", out_data.sum_bits, 32'd0);
            end
            else
            begin
                if (out_data.sum_bits !== expected_sums[0].sum_bits)
                    report_mismatch("sum_bits", out_data.sum_bits, expected_sums[0].sum_bits);
                if (out_data.overflow !== expected_sums[0].overflow)
                    report_mismatch("overflow", {31'd0, out_data.overflow},
                                    {31'd0, expected_sums[0].overflow});
                if (out_data.underflow !== expected_sums[0].underflow)
                    report_mismatch("underflow", {31'd0, out_data.underflow},
                                    {31'd0, expected_sums[0].underflow});
                overflow_seen  += out_data.overflow;
                underflow_seen += out_data.underflow;
                sums_checked++;
                void'(expected_sums.pop_front());
            end
        end
    end

    // Random bit pattern biased towards nearby exponents and special fields.
    function automatic logic [31:0] random_float(input logic [7:0] exp_near);
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0: f[30:23] = 8'd0;
            1: f[30:23] = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd254;
            2: f[30:23] = 8'($urandom_range(1, 3));
            3, 4, 5, 6: f[30:23] = exp_near + 8'($urandom_range(0, 4)) - 8'd2;
            default: ;
        endcase
        return f;
    endfunction

    // Edge cases: zeros, cancellation, extremes, overflow and underflow.
    task automatic test_directed();
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h0000_0000);
        send_pair(32'h007F_FFFF, 32'h807F_FFFF);
        send_pair(32'h3F80_0000, 32'hBF80_0000);
        send_pair(32'h3F80_0000, 32'h3F80_0000);
        send_pair(32'h3F80_0000, 32'h0000_1234);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_pair(32'hFF7F_FFFF, 32'hFF00_0000);
        send_pair(32'h7FFF_FFFF, 32'h3F80_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0080_0001, 32'h8080_0000);
        send_pair(32'h0080_0000, 32'h8100_0000);
        send_pair(32'h3F80_0000, 32'hB380_0000);
        send_pair(32'h3F80_0000, 32'h0080_0000);
        send_pair(32'h4B80_0000, 32'hBF80_0000);
        send_pair(32'h4000_0000, 32'hBFFF_FFFF);
        send_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Random operand pairs, the second often with an exponent close to the first.
    task automatic test_random(input int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = random_float(8'($urandom_range(0, 255)));
            send_pair(a, random_float(a[30:23]));
        end
    endtask

    // Long receiver hold-off while the sender keeps offering pairs.
    task automatic test_backpressure();
        hold_cycles = 40;
        burst_left  = 60;
        test_random(30);
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        error_count = 0;
        sums_checked = 0;
        items_sent = 0;
        overflow_seen = 0;
        underflow_seen = 0;
        hold_cycles = 0;
        stall_random = 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        stall_random = 1'b1;
        test_random(500);
        test_backpressure();
        stall_random = 1'b0;
        test_random(200);
        stall_random = 1'b1;
        test_random(400);
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d operand pairs, checked %0d sums (%0d overflows, %0d underflows).",
                 items_sent, sums_checked, overflow_seen, underflow_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout waiting for results.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
